// ----- rtl/core/sfs_pkg.sv -----
// sfs_pkg: shared constants, request codes and control types of the symbol
// frequency sorter. Used by every module in rtl/core, depends on nothing.
`default_nettype none

package sfs_pkg;

  // default sizing
  localparam int SYMBOL_BITS_DEF = 8;
  localparam int COUNT_BITS_DEF  = 32;

  // fixed port widths
  localparam int REQ_W    = 2;
  localparam int SYM_PW   = 8;
  localparam int WEIGHT_W = 32;
  localparam int POS_W    = 8;
  localparam int CNT_PW   = 32;
  localparam int USED_PW  = 9;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SORT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

  // cell operations
  typedef logic [2:0] cell_op_t;
  localparam cell_op_t OP_HOLD    = 3'd0;
  localparam cell_op_t OP_WRITE   = 3'd1;
  localparam cell_op_t OP_SRT_CLR = 3'd2;
  localparam cell_op_t OP_INSERT  = 3'd3;
  localparam cell_op_t OP_COPY    = 3'd4;
  localparam cell_op_t OP_DRAIN   = 3'd5;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

  typedef struct packed {
    logic wr_en;
    logic set_pres;
    logic clr_all;
  } map_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/sfs_cell.sv -----
// sfs_cell: one list position of the frequency table, with its list entry and
// its sorting entry. Depends on sfs_pkg for the operation codes.
`default_nettype none

module sfs_cell #(
  parameter int SYM_W    = sfs_pkg::SYMBOL_BITS_DEF,
  parameter int CNT_W    = sfs_pkg::COUNT_BITS_DEF,
  parameter int CELL_IDX = 0
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  sfs_pkg::cell_ctl_t    ctl,
  input  wire [SYM_W-1:0]       addr,
  input  wire [SYM_W-1:0]       key_sym,
  input  wire [CNT_W-1:0]       key_cnt,
  input  wire                   prev_ge,
  input  wire                   prev_srt_vld,
  input  wire [SYM_W-1:0]       prev_srt_sym,
  input  wire [CNT_W-1:0]       prev_srt_cnt,
  input  wire [SYM_W-1:0]       next_lst_sym,
  input  wire [CNT_W-1:0]       next_lst_cnt,
  input  wire [SYM_W-1:0]       next_srt_sym,
  input  wire [CNT_W-1:0]       next_srt_cnt,
  output logic [SYM_W-1:0]      lst_sym,
  output logic [CNT_W-1:0]      lst_cnt,
  output logic [SYM_W-1:0]      srt_sym,
  output logic [CNT_W-1:0]      srt_cnt,
  output logic                  srt_vld,
  output logic                  ge
);

  logic [SYM_W-1:0] lst_sym_r;
  logic [CNT_W-1:0] lst_cnt_r;
  logic [SYM_W-1:0] srt_sym_r;
  logic [CNT_W-1:0] srt_cnt_r;
  logic             srt_vld_r;
  logic             hit;
  logic             take_key;

  assign hit = (addr == SYM_W'(CELL_IDX));
  // sorted row is descending, so the incoming key goes before equal counts
  assign ge       = !srt_vld_r || (key_cnt >= srt_cnt_r);
  assign take_key = ge && !prev_ge;

  always_ff @(posedge clk) begin
    case (ctl.op)
      sfs_pkg::OP_WRITE: begin
        if (hit) begin
          lst_sym_r <= key_sym;
          lst_cnt_r <= key_cnt;
        end
      end
      sfs_pkg::OP_INSERT: begin
        lst_sym_r <= next_lst_sym;
        lst_cnt_r <= next_lst_cnt;
        if (take_key) begin
          srt_sym_r <= key_sym;
          srt_cnt_r <= key_cnt;
        end else if (prev_ge) begin
          srt_sym_r <= prev_srt_sym;
          srt_cnt_r <= prev_srt_cnt;
        end
      end
      sfs_pkg::OP_COPY: begin
        lst_sym_r <= srt_sym_r;
        lst_cnt_r <= srt_cnt_r;
      end
      sfs_pkg::OP_DRAIN: begin
        srt_sym_r <= next_srt_sym;
        srt_cnt_r <= next_srt_cnt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srt_vld_r <= 1'b0;
    end else begin
      case (ctl.op)
        sfs_pkg::OP_SRT_CLR: begin
          srt_vld_r <= 1'b0;
        end
        sfs_pkg::OP_INSERT: begin
          if (take_key) begin
            srt_vld_r <= 1'b1;
          end else if (prev_ge) begin
            srt_vld_r <= prev_srt_vld;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign lst_sym = lst_sym_r;
  assign lst_cnt = lst_cnt_r;
  assign srt_sym = srt_sym_r;
  assign srt_cnt = srt_cnt_r;
  assign srt_vld = srt_vld_r;

endmodule

`default_nettype wire

// ----- rtl/core/sfs_slot_map.sv -----
// sfs_slot_map: per-symbol presence bits and the symbol to list position
// memory. Depends on sfs_pkg for the control struct.
`default_nettype none

module sfs_slot_map #(
  parameter int SYM_W = sfs_pkg::SYMBOL_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  sfs_pkg::map_ctl_t   ctl,
  input  wire [SYM_W-1:0]     rd_sym,
  input  wire [SYM_W-1:0]     wr_sym,
  input  wire [SYM_W-1:0]     wr_slot,
  output logic [SYM_W-1:0]    slot_q,
  output logic                pres_q
);

  localparam int N = 1 << SYM_W;

  logic [N-1:0]     present_r;
  logic [SYM_W-1:0] slot_mem [N];
  logic [SYM_W-1:0] slot_q_r;
  logic             pres_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (ctl.clr_all) begin
      present_r <= '0;
    end else if (ctl.set_pres) begin
      present_r[wr_sym] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      slot_mem[wr_sym] <= wr_slot;
    end
    slot_q_r <= slot_mem[rd_sym];
    pres_q_r <= present_r[rd_sym];
  end

  assign slot_q = slot_q_r;
  assign pres_q = pres_q_r;

endmodule

`default_nettype wire

// ----- rtl/core/symbol_frequency_sorter.sv -----
// symbol_frequency_sorter: top level of the symbol frequency table, a row of
// sfs_cell list positions plus the sfs_slot_map lookup. Depends on sfs_pkg.
//
// Usage: one request channel (in_valid / in_stall) carries add, clear, sort
// and read requests; only a read gives a result on the out_ channel
// (out_valid / out_stall), held in an output register.
// Steps per request, counted from acceptance:
//   add   - the slot lookup is registered at acceptance, the saturating
//           update of the chosen cell happens in the next cycle
//   clear - takes effect at the accepting edge
//   read  - result is in the output register after the accepting edge
//   sort  - for n entries (n below two: nothing is done): the accepting
//           cycle empties the sorting row, the list head then streams into
//           it entry by entry, a copy step, then the slot memory is rewritten
// One request is in progress at a time; in_stall is high while an add or sort
// is busy, and while a finished read result waits behind a stalled receiver.
// Reset clears the entry count and the presence bits; no clearing pass is
// needed, list storage is only read below the entry count.
`default_nettype none

module symbol_frequency_sorter #(
  parameter int SYMBOL_BITS = sfs_pkg::SYMBOL_BITS_DEF,
  parameter int COUNT_BITS  = sfs_pkg::COUNT_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [sfs_pkg::REQ_W-1:0]     in_req_type,
  input  wire [sfs_pkg::SYM_PW-1:0]    in_symbol,
  input  wire [sfs_pkg::WEIGHT_W-1:0]  in_weight,
  input  wire [sfs_pkg::POS_W-1:0]     in_position,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [sfs_pkg::SYM_PW-1:0]   out_entry_symbol,
  output logic [sfs_pkg::CNT_PW-1:0]   out_entry_count,
  output logic                         out_entry_valid,
  output logic                         out_is_last,
  output logic [sfs_pkg::USED_PW-1:0]  out_entries_used
);

  localparam int SYM_W = SYMBOL_BITS;
  localparam int CNT_W = COUNT_BITS;
  localparam int N     = 1 << SYM_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_INS   = 3'd2;
  localparam logic [2:0] ST_COPY  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [SYM_W:0]   used_r, used_nxt;
  logic [SYM_W-1:0] step_r, step_nxt;
  logic [SYM_W-1:0] sym_r;
  logic [CNT_W-1:0] w_r;

  logic             out_valid_r, out_valid_nxt;
  logic [sfs_pkg::SYM_PW-1:0]  out_sym_r;
  logic [sfs_pkg::CNT_PW-1:0]  out_cnt_r;
  logic                        out_ev_r;
  logic                        out_last_r;
  logic [sfs_pkg::USED_PW-1:0] out_used_r;

  logic accept;
  logic take_out;
  logic step_last;

  // input conditioning
  logic [SYM_W+sfs_pkg::SYM_PW-1:0]    sym_wide;
  logic [SYM_W-1:0]                    sym_in;
  logic [CNT_W+sfs_pkg::WEIGHT_W-1:0]  w_wide;
  logic [CNT_W-1:0]                    w_in;

  // read path
  logic [SYM_W+sfs_pkg::POS_W:0]       pos_wide;
  logic [SYM_W+sfs_pkg::POS_W:0]       used_wide;
  logic [SYM_W-1:0]                    pos_idx;
  logic                                pos_ok;
  logic                                pos_last;
  logic [SYM_W+sfs_pkg::SYM_PW-1:0]    rd_sym_wide;
  logic [CNT_W+sfs_pkg::CNT_PW-1:0]    rd_cnt_wide;
  logic [SYM_W+sfs_pkg::USED_PW:0]     used_out_wide;

  // add path
  logic [SYM_W-1:0] slot_q;
  logic             pres_q;
  logic [CNT_W-1:0] cur_cnt;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] sum_sat;

  // cell row
  sfs_pkg::cell_ctl_t cell_ctl;
  sfs_pkg::map_ctl_t  map_ctl;
  logic [SYM_W-1:0]   cell_addr;
  logic [SYM_W-1:0]   key_sym;
  logic [CNT_W-1:0]   key_cnt;
  logic [SYM_W-1:0]   map_wr_sym;
  logic [SYM_W-1:0]   map_wr_slot;

  logic [SYM_W-1:0] lst_sym_a [N];
  logic [CNT_W-1:0] lst_cnt_a [N];
  logic [SYM_W-1:0] srt_sym_a [N];
  logic [CNT_W-1:0] srt_cnt_a [N];
  logic             srt_vld_a [N];
  logic             ge_a      [N];

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign take_out  = out_valid_r && !out_stall;
  assign step_last = ({1'b0, step_r} == (used_r - 1'b1));

  assign sym_wide = {{SYM_W{1'b0}}, in_symbol};
  assign sym_in   = sym_wide[SYM_W-1:0];
  assign w_wide   = {{CNT_W{1'b0}}, in_weight};
  assign w_in     = (|w_wide[CNT_W+sfs_pkg::WEIGHT_W-1:CNT_W]) ? {CNT_W{1'b1}}
                                                                 : w_wide[CNT_W-1:0];

  assign pos_wide  = {{(SYM_W+1){1'b0}}, in_position};
  assign used_wide = {{sfs_pkg::POS_W{1'b0}}, used_r};
  assign pos_idx   = pos_wide[SYM_W-1:0];
  assign pos_ok    = (pos_wide < used_wide);
  assign pos_last  = ((pos_wide + 1'b1) == used_wide);

  assign rd_sym_wide   = {{sfs_pkg::SYM_PW{1'b0}}, lst_sym_a[pos_idx]};
  assign rd_cnt_wide   = {{sfs_pkg::CNT_PW{1'b0}}, lst_cnt_a[pos_idx]};
  assign used_out_wide = {{sfs_pkg::USED_PW{1'b0}}, used_r};

  assign cur_cnt = lst_cnt_a[slot_q];
  assign sum     = {1'b0, cur_cnt} + {1'b0, w_r};
  assign sum_sat = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];

  // sequencing and cell / map control
  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    step_nxt     = step_r;
    cell_ctl.op  = sfs_pkg::OP_HOLD;
    cell_addr    = slot_q;
    key_sym      = sym_r;
    key_cnt      = w_r;
    map_ctl      = '0;
    map_wr_sym   = sym_r;
    map_wr_slot  = used_r[SYM_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            sfs_pkg::REQ_ADD: begin
              state_nxt = ST_ADD;
            end
            sfs_pkg::REQ_CLEAR: begin
              map_ctl.clr_all = 1'b1;
              used_nxt        = '0;
            end
            sfs_pkg::REQ_SORT: begin
              if (used_r >= (SYM_W+1)'(2)) begin
                cell_ctl.op = sfs_pkg::OP_SRT_CLR;
                step_nxt    = '0;
                state_nxt   = ST_INS;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD: begin
        state_nxt   = ST_IDLE;
        cell_ctl.op = sfs_pkg::OP_WRITE;
        if (pres_q) begin
          cell_addr = slot_q;
          key_cnt   = sum_sat;
        end else if (used_r < (SYM_W+1)'(N)) begin
          cell_addr        = used_r[SYM_W-1:0];
          map_ctl.wr_en    = 1'b1;
          map_ctl.set_pres = 1'b1;
          used_nxt         = used_r + 1'b1;
        end else begin
          cell_ctl.op = sfs_pkg::OP_HOLD;
        end
      end
      ST_INS: begin
        // list head streams into the sorting row
        cell_ctl.op = sfs_pkg::OP_INSERT;
        key_sym     = lst_sym_a[0];
        key_cnt     = lst_cnt_a[0];
        step_nxt    = step_r + 1'b1;
        if (step_last) begin
          state_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        cell_ctl.op = sfs_pkg::OP_COPY;
        step_nxt    = '0;
        state_nxt   = ST_DRAIN;
      end
      ST_DRAIN: begin
        // sorted row shifts out at cell 0 while the slot memory is rewritten
        cell_ctl.op   = sfs_pkg::OP_DRAIN;
        map_ctl.wr_en = 1'b1;
        map_wr_sym    = srt_sym_a[0];
        map_wr_slot   = step_r;
        step_nxt      = step_r + 1'b1;
        if (step_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take_out) begin
      out_valid_nxt = 1'b0;
    end
    if (accept && (in_req_type == sfs_pkg::REQ_READ)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sym_r <= sym_in;
      w_r   <= w_in;
    end
    if (accept && (in_req_type == sfs_pkg::REQ_READ)) begin
      out_sym_r  <= pos_ok ? rd_sym_wide[sfs_pkg::SYM_PW-1:0] : '0;
      out_cnt_r  <= pos_ok ? rd_cnt_wide[sfs_pkg::CNT_PW-1:0] : '0;
      out_ev_r   <= pos_ok;
      out_last_r <= pos_ok && pos_last;
      out_used_r <= used_out_wide[sfs_pkg::USED_PW-1:0];
    end
  end

  sfs_slot_map #(
    .SYM_W (SYM_W)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (map_ctl),
    .rd_sym  (sym_in),
    .wr_sym  (map_wr_sym),
    .wr_slot (map_wr_slot),
    .slot_q  (slot_q),
    .pres_q  (pres_q)
  );

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic             p_ge;
    logic             p_vld;
    logic [SYM_W-1:0] p_sym;
    logic [CNT_W-1:0] p_cnt;
    logic [SYM_W-1:0] nl_sym;
    logic [CNT_W-1:0] nl_cnt;
    logic [SYM_W-1:0] ns_sym;
    logic [CNT_W-1:0] ns_cnt;

    if (k == 0) begin : g_head
      assign p_ge  = 1'b0;
      assign p_vld = 1'b0;
      assign p_sym = '0;
      assign p_cnt = '0;
    end else begin : g_mid
      assign p_ge  = ge_a[k-1];
      assign p_vld = srt_vld_a[k-1];
      assign p_sym = srt_sym_a[k-1];
      assign p_cnt = srt_cnt_a[k-1];
    end

    if (k == N-1) begin : g_tail
      assign nl_sym = '0;
      assign nl_cnt = '0;
      assign ns_sym = '0;
      assign ns_cnt = '0;
    end else begin : g_body
      assign nl_sym = lst_sym_a[k+1];
      assign nl_cnt = lst_cnt_a[k+1];
      assign ns_sym = srt_sym_a[k+1];
      assign ns_cnt = srt_cnt_a[k+1];
    end

    sfs_cell #(
      .SYM_W    (SYM_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (cell_ctl),
      .addr         (cell_addr),
      .key_sym      (key_sym),
      .key_cnt      (key_cnt),
      .prev_ge      (p_ge),
      .prev_srt_vld (p_vld),
      .prev_srt_sym (p_sym),
      .prev_srt_cnt (p_cnt),
      .next_lst_sym (nl_sym),
      .next_lst_cnt (nl_cnt),
      .next_srt_sym (ns_sym),
      .next_srt_cnt (ns_cnt),
      .lst_sym      (lst_sym_a[k]),
      .lst_cnt      (lst_cnt_a[k]),
      .srt_sym      (srt_sym_a[k]),
      .srt_cnt      (srt_cnt_a[k]),
      .srt_vld      (srt_vld_a[k]),
      .ge           (ge_a[k])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_entry_symbol = out_sym_r;
  assign out_entry_count  = out_cnt_r;
  assign out_entry_valid  = out_ev_r;
  assign out_is_last      = out_last_r;
  assign out_entries_used = out_used_r;

endmodule

`default_nettype wire
